### hdl/asidl_pkg.sv
package asidl_pkg;

   localparam int ELEMENT_W = 32;
   localparam int COUNT_W   = 7;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SEARCH = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_TRUE  = 2'd0,
      ST_FALSE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_RESP
   } state_type;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic       done;
      status_type status;
   } result_type;

endpackage

### hdl/array_set_insert_delete_lookup.sv
// Each request scans the held entries in order from the front; the unused action
// code skips the scan. A remove that hits then shifts each later entry down one
// place, one entry a cycle. The block takes one request at a time: the next beat
// is taken only after the result has loaded into the output register.
// Reset clears the count and control state; the store itself is not cleared.
module array_set_insert_delete_lookup #(
   parameter int CAPACITY = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic signed [asidl_pkg::ELEMENT_W-1:0] req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [asidl_pkg::COUNT_W-1:0]      rsp_count,
   output logic                               rsp_is_empty
);

   import asidl_pkg::*;

   // Only the low bits of the element take part, capped by the port width
   localparam int SW = (ELEM_WIDTH < ELEMENT_W) ? ELEM_WIDTH : ELEMENT_W;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;

   result_type       res;
   logic [CW-1:0]    count;
   logic [OW-1:0]    count_ext;
   logic             slot_free;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [SW-1:0]    mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [SW-1:0]    mem_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_is_empty_ff, rsp_is_empty_in;

   // The element store: one write and one registered read per cycle
   asidl_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (SW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Sequencer: pipelined linear search, append, and shift-down on remove
   asidl_ctrl #(
      .CAPACITY (CAPACITY),
      .SW       (SW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_value  (req_element[SW-1:0]),
      .req_ready  (req_ready),
      .slot_free  (slot_free),
      .res        (res),
      .count      (count),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // Output register: the result beat waits here while the sequencer goes idle
   // and takes the next request. The slot frees as soon as the beat is taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign count_ext = OW'(count);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res.done) begin
         // load the finished result; count is masked to its field width
         rsp_valid_in    = 1'b1;
         rsp_status_in   = res.status;
         rsp_count_in    = count_ext[COUNT_W-1:0];
         rsp_is_empty_in = (count == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

endmodule

### hdl/asidl_mem.sv
module asidl_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/asidl_ctrl.sv
module asidl_ctrl #(
   parameter int CAPACITY = 64,
   parameter int SW = 32,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   input  logic [SW-1:0]          req_value,
   output logic                   req_ready,
   input  logic                   slot_free,
   output asidl_pkg::result_type  res,
   output logic [CW-1:0]          count,
   output logic                   mem_we,
   output logic [AW-1:0]          mem_waddr,
   output logic [SW-1:0]          mem_wdata,
   output logic [AW-1:0]          mem_raddr,
   input  logic [SW-1:0]          mem_rdata
);

   import asidl_pkg::*;

   state_type   state_ff, state_in;
   action_type  action_ff, action_in;
   status_type  status_ff, status_in;
   logic [SW-1:0] value_ff, value_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;    // next address to read
   logic [CW-1:0] pidx_ff, pidx_in;  // address of the read in flight
   logic          pend_ff, pend_in;
   logic          hit;
   logic          last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      action_ff <= action_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      pidx_ff   <= pidx_in;
   end

   assign hit  = pend_ff && (mem_rdata == value_ff);
   assign last = (idx_ff == count_ff);

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pidx_in    = pidx_ff;
      pend_in    = pend_ff;
      req_ready  = 1'b0;
      res.done   = 1'b0;
      res.status = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = count_ff[AW-1:0];
      mem_wdata  = value_ff;
      mem_raddr  = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = action_type'(req_action);
               value_in  = req_value;
               idx_in    = '0;
               pend_in   = 1'b0;
               state_in  = S_SEARCH;
            end
         end

         S_SEARCH: begin
            if (action_ff != ACT_ADD && action_ff != ACT_REMOVE &&
                action_ff != ACT_SEARCH) begin
               // unused code: report false, touch nothing
               status_in = ST_FALSE;
               state_in  = S_RESP;
            end else if (hit) begin
               case (action_ff)
                  ACT_REMOVE: begin
                     idx_in   = pidx_ff + 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT;
                  end
                  ACT_ADD: begin
                     status_in = ST_FALSE;
                     state_in  = S_RESP;
                  end
                  default: begin
                     status_in = ST_TRUE;
                     state_in  = S_RESP;
                  end
               endcase
            end else if (last && !pend_ff) begin
               state_in = S_RESP;
               if (action_ff == ACT_ADD) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     // append at the end of the held entries
                     mem_we    = 1'b1;
                     count_in  = count_ff + 1'b1;
                     status_in = ST_TRUE;
                  end
               end else begin
                  status_in = ST_FALSE;
               end
            end else begin
               pend_in = !last;
               pidx_in = idx_ff;
               if (!last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_SHIFT: begin
            // move each later entry down one place, one read and one write a cycle
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(pidx_ff - 1'b1);
               mem_wdata = mem_rdata;
            end
            if (!last) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in  = count_ff - 1'b1;
                  status_in = ST_TRUE;
                  state_in  = S_RESP;
               end
            end
         end

         S_RESP: begin
            res.done = slot_free;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count = count_ff;

endmodule

### test/array_set_insert_delete_lookup_checker.sv
module array_set_insert_delete_lookup_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [asidl_pkg::ELEMENT_W-1:0] req_element,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_status,
   input  logic [asidl_pkg::COUNT_W-1:0]   rsp_count,
   input  logic                            rsp_is_empty,
   output int unsigned                     mismatches,
   output int unsigned                     replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import asidl_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } set_reply_type;

   // Shadow copy of the set, kept compact in insertion order like the block
   logic [ELEMENT_W-1:0] held_elems [CAPACITY];
   int unsigned          held_count;
   set_reply_type        owed_replies [$];
   int unsigned          fault_total;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      fault_total++;
   endtask

   // Apply one request to the shadow set and return the reply it earns
   function automatic set_reply_type predict_set_reply(input logic [1:0] act,
                                                       input logic [ELEMENT_W-1:0] elem);
      int unsigned   pos;
      set_reply_type reply;
      pos = held_count;
      for (int i = 0; i < held_count; i++) begin
         if (held_elems[i] == elem) begin
            pos = i;
            break;
         end
      end
      reply.status = ST_FALSE;
      case (act)
         ACT_ADD: begin
            if (pos < held_count) begin
               reply.status = ST_FALSE;
            end else if (held_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               held_elems[held_count] = elem;
               held_count++;
               reply.status = ST_TRUE;
            end
         end
         ACT_REMOVE: begin
            if (pos < held_count) begin
               for (int i = pos; i + 1 < held_count; i++) held_elems[i] = held_elems[i + 1];
               held_count--;
               reply.status = ST_TRUE;
            end
         end
         ACT_SEARCH: begin
            if (pos < held_count) reply.status = ST_TRUE;
         end
         default: ;
      endcase
      reply.count    = COUNT_W'(held_count);
      reply.is_empty = (held_count == 0);
      return reply;
   endfunction

   always @(posedge clock) begin
      set_reply_type want;
      if (reset) begin
         held_count = 0;
         owed_replies.delete();
      end else begin
         // Retire the result beat first: it belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               report_mismatch("result beat with no request pending", 0, 1);
            end else begin
               want = owed_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_count !== want.count)
                  report_mismatch("count", want.count, rsp_count);
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", want.is_empty, rsp_is_empty);
            end
         end
         if (req_valid && req_ready)
            owed_replies.push_back(predict_set_reply(req_action, req_element));
      end
      mismatches   <= fault_total;
      replies_owed <= owed_replies.size();
   end

endmodule

### test/array_set_insert_delete_lookup_tb.sv
module array_set_insert_delete_lookup_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import asidl_pkg::*;

   localparam int CAPACITY        = 64;
   localparam int POOL_SIZE       = 96;    // more candidates than slots, so fills overflow
   localparam int REQUEST_GOAL    = 1650;
   localparam int IDLE_LIMIT      = 5000;  // cycles without any beat before giving up
   localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall that backs up the input
   localparam int SETTLE_CYCLES   = 150;   // well over the worst-case item latency
   localparam int QUIET_FIRST     = 900;   // window with no idling on either side
   localparam int QUIET_LAST      = 1150;
   // Action code the block must ignore (reply false, state untouched)
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action   = ACT_SEARCH;
   logic [ELEMENT_W-1:0] req_element  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic [1:0]           rsp_status;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 rsp_is_empty;

   int unsigned mismatches;
   int unsigned replies_owed;

   // Requests accepted, not counting the ignored action code
   int unsigned requests_sent = 0;
   // Candidate elements: low bits hold the slot index, so every entry is distinct
   logic [ELEMENT_W-1:0] element_pool [POOL_SIZE];

   array_set_insert_delete_lookup #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEMENT_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_element  (req_element),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   array_set_insert_delete_lookup_checker #(
      .CAPACITY (CAPACITY)
   ) set_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_element  (req_element),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .mismatches   (mismatches),
      .replies_owed (replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort when the channels go quiet for too long; reset clears the count
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stall about 15% of cycles, hold off once for a long
   // stretch so the block fills and drops req_ready, and stay always-ready
   // through the quiet window.
   int unsigned replies_taken = 0;
   int unsigned hold_left     = 0;
   bit          hold_done     = 1'b0;
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) replies_taken <= replies_taken + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && replies_taken >= 300) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (replies_taken >= QUIET_FIRST && replies_taken < QUIET_LAST) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 15);
      end
   end

   // Offer one request beat and hold it until accepted. On some beats drop
   // valid for a random gap first (outside the quiet window); otherwise keep
   // valid high so back-to-back beats never lower and raise it in the same step.
   task automatic send_request(input logic [1:0] act, input logic [ELEMENT_W-1:0] elem);
      int unsigned gap;
      gap = 0;
      if (!(requests_sent >= QUIET_FIRST && requests_sent < QUIET_LAST) &&
          $urandom_range(99) < 15)
         gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_element <= elem;
      do @(posedge clock); while (!req_ready);
      if (act != ACT_UNUSED) requests_sent++;
   endtask

   function automatic logic [ELEMENT_W-1:0] fresh_pool_value(input int idx);
      logic [ELEMENT_W-1:0] value;
      value      = $urandom();
      value[6:0] = idx[6:0];
      return value;
   endfunction

   function automatic logic [ELEMENT_W-1:0] any_pool_value();
      return element_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   // Extremes, every action, duplicate, miss, shift from the middle and
   // front, the ignored action code on empty and non-empty sets.
   task automatic run_directed_checks();
      send_request(ACT_SEARCH, 32'h0000_0000);   // search on empty set
      send_request(ACT_REMOVE, 32'h0000_0005);   // remove on empty set
      send_request(ACT_UNUSED, 32'h0000_0000);   // ignored code, empty
      send_request(ACT_ADD,    32'h8000_0000);   // most negative
      send_request(ACT_ADD,    32'h7FFF_FFFF);   // most positive
      send_request(ACT_ADD,    32'hFFFF_FFFF);   // minus one
      send_request(ACT_ADD,    32'h0000_0000);
      send_request(ACT_ADD,    32'h7FFF_FFFF);   // duplicate add
      send_request(ACT_SEARCH, 32'h8000_0000);   // hit at the front
      send_request(ACT_SEARCH, 32'h0000_0001);   // miss
      send_request(ACT_REMOVE, 32'h7FFF_FFFF);   // remove from the middle, shift down
      send_request(ACT_SEARCH, 32'hFFFF_FFFF);   // still found after the shift
      send_request(ACT_REMOVE, 32'h7FFF_FFFF);   // already gone
      send_request(ACT_UNUSED, 32'hFFFF_FFFF);   // ignored code, non-empty
      send_request(ACT_REMOVE, 32'h8000_0000);   // remove the front entry
      send_request(ACT_REMOVE, 32'h0000_0000);   // remove the last entry
      send_request(ACT_REMOVE, 32'hFFFF_FFFF);   // back to empty
      send_request(ACT_ADD,    32'h5555_5555);
      send_request(ACT_ADD,    32'hAAAA_AAAA);
      send_request(ACT_SEARCH, 32'hAAAA_AAAA);
      send_request(ACT_REMOVE, 32'h5555_5555);
      send_request(ACT_REMOVE, 32'hAAAA_AAAA);
   endtask

   // Walk more distinct candidates than there are slots: the tail hits the
   // full store, both as refusals and as duplicates of held entries.
   task automatic run_fill_episode();
      int start;
      start = $urandom_range(POOL_SIZE - 1);
      for (int k = 0; k < CAPACITY + 16; k++) begin
         if ($urandom_range(9) == 0) send_request(ACT_SEARCH, any_pool_value());
         send_request(ACT_ADD, element_pool[(start + k) % POOL_SIZE]);
      end
   endtask

   // Remove a run of candidates; hits land anywhere in the array
   task automatic run_drain_episode();
      int start;
      start = $urandom_range(POOL_SIZE - 1);
      for (int k = 0; k < 70; k++) begin
         if ($urandom_range(9) == 0) send_request(ACT_SEARCH, any_pool_value());
         send_request(ACT_REMOVE, element_pool[(start + k) % POOL_SIZE]);
      end
   endtask

   task automatic run_mixed_episode();
      int unsigned          roll;
      logic [ELEMENT_W-1:0] elem;
      for (int k = 0; k < 40; k++) begin
         roll = $urandom_range(99);
         elem = ($urandom_range(9) == 0) ? $urandom() : any_pool_value();
         if (roll < 40)      send_request(ACT_ADD, elem);
         else if (roll < 70) send_request(ACT_REMOVE, elem);
         else if (roll < 97) send_request(ACT_SEARCH, elem);
         else                send_request(ACT_UNUSED, elem);
      end
   endtask

   // Swap out a few candidates; remove each old value first so the store
   // does not clog with values the pool no longer reaches.
   task automatic retire_pool_entries();
      int idx;
      for (int k = 0; k < 12; k++) begin
         idx = $urandom_range(POOL_SIZE - 1);
         send_request(ACT_REMOVE, element_pool[idx]);
         element_pool[idx] = fresh_pool_value(idx);
      end
   endtask

   initial begin
      int unsigned roll;
      for (int i = 0; i < POOL_SIZE; i++) element_pool[i] = fresh_pool_value(i);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed_checks();
      // Open with a fill so the full store is reached early on
      run_fill_episode();
      while (requests_sent < REQUEST_GOAL) begin
         roll = $urandom_range(99);
         if (roll < 20)      run_fill_episode();
         else if (roll < 40) run_drain_episode();
         else if (roll < 50) retire_pool_entries();
         else                run_mixed_episode();
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then give the block time to misbehave
      do @(posedge clock); while (replies_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
